@@ rtl/ratchet_ctr_aes_sector_cipher_core_macros.svh @@
// Assertion macros for the ratchet CTR sector cipher core.
`ifndef RATCHET_CTR_AES_SECTOR_CIPHER_CORE_MACROS_SVH
`define RATCHET_CTR_AES_SECTOR_CIPHER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define RCA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define RCA_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define RCA_ASSERT(lbl, clk, rstn, prop)
`define RCA_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif
`endif

@@ rtl/rca_pkg.sv @@
// ----------------------------------------------------------------------------
// rca_pkg
// Types, constants and AES helper functions for the sector cipher core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package rca_pkg;

  localparam int unsigned RegCount = 8;
  localparam int unsigned AddrW    = 6;

  typedef enum logic [2:0] {
    RegMk0 = 3'd0, RegMk1 = 3'd1, RegMk2 = 3'd2, RegMk3 = 3'd3,
    RegRk0 = 3'd4, RegRk1 = 3'd5, RegRk2 = 3'd6, RegRk3 = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    StIdle, StLoad, StRound, StDone
  } state_e;

  typedef enum logic [1:0] {
    PhDerive, PhStream, PhRatchet
  } phase_e;

  typedef struct packed {
    logic        func;
    logic        first;
    logic [63:0] sector;
    logic [31:0] block_index;
    logic [63:0] in_hi;
    logic [63:0] in_lo;
  } req_t;

  typedef struct packed {
    logic [63:0] out_hi;
    logic [63:0] out_lo;
  } rsp_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] tbl [256];
    tbl = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return tbl[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // Bytes are packed little-endian: byte i sits in bits 8*i+7 .. 8*i.
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
    logic [127:0] t;
    logic [127:0] m;
    logic [7:0]   a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[(c*4+r)*8 +: 8] = sbox(s[((((c + r) & 3) * 4) + r)*8 +: 8]);
      end
    end
    m = t;
    for (int c = 0; c < 4; c++) begin
      a0 = t[(c*4)*8 +: 8];
      a1 = t[(c*4+1)*8 +: 8];
      a2 = t[(c*4+2)*8 +: 8];
      a3 = t[(c*4+3)*8 +: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      m[(c*4)*8 +: 8]   = a0 ^ al ^ xtime(a0 ^ a1);
      m[(c*4+1)*8 +: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      m[(c*4+2)*8 +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      m[(c*4+3)*8 +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    return last ? t : m;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // Byte rotation: tmp[0] = w[1] ... tmp[3] = w[0].
  function automatic logic [31:0] rot_word(input logic [31:0] w);
    return {w[7:0], w[31:8]};
  endfunction

  // Advance an AES-128 key by one round: k holds the current 4 words.
  function automatic logic [127:0] kexp128(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, tmp;
    tmp = sub_word(rot_word(k[127:96])) ^ {24'h0, rc};
    w0  = k[31:0] ^ tmp;
    w1  = k[63:32] ^ w0;
    w2  = k[95:64] ^ w1;
    w3  = k[127:96] ^ w2;
    return {w3, w2, w1, w0};
  endfunction

  // Advance an AES-256 key window by 8 words (two round keys).
  function automatic logic [255:0] kexp256(input logic [255:0] k, input logic [7:0] rc);
    logic [31:0] w [8];
    logic [31:0] tmp;
    for (int i = 0; i < 8; i++) begin
      w[i] = k[i*32 +: 32];
    end
    tmp  = sub_word(rot_word(w[7])) ^ {24'h0, rc};
    w[0] = w[0] ^ tmp;
    w[1] = w[1] ^ w[0];
    w[2] = w[2] ^ w[1];
    w[3] = w[3] ^ w[2];
    w[4] = w[4] ^ sub_word(w[3]);
    w[5] = w[5] ^ w[4];
    w[6] = w[6] ^ w[5];
    w[7] = w[7] ^ w[6];
    return {w[7], w[6], w[5], w[4], w[3], w[2], w[1], w[0]};
  endfunction

  function automatic logic [7:0] next_rc(input logic [7:0] rc);
    return xtime(rc);
  endfunction

endpackage
`default_nettype wire

@@ rtl/rca_stream_if.sv @@
// ----------------------------------------------------------------------------
// rca_stream_if
// Valid/ready channel carrying one payload of type T.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface rca_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ rtl/ratchet_ctr_aes_sector_cipher_core.sv @@
// ----------------------------------------------------------------------------
// ratchet_ctr_aes_sector_cipher_core
// AES counter-mode sector cipher with a per-block key ratchet.
// ----------------------------------------------------------------------------
// One block is processed at a time by a single shared AES round unit with an
// on-the-fly key schedule. A block is accepted, then takes a load step and
// 10 rounds for the keystream, a load step and 14 rounds for the ratchet
// update, and a done step that raises the result. When first is set, the
// sector key derivation adds a load step and 14 rounds before these. The
// output register holds the result until taken; the next block is accepted
// in the cycle after the result has left.
`timescale 1ns / 1ps
`default_nettype none
`include "ratchet_ctr_aes_sector_cipher_core_macros.svh"
module ratchet_ctr_aes_sector_cipher_core
  import rca_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  rca_stream_if.sink             req_if,
  rca_stream_if.source           rsp_if,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [AddrW-1:0]  paddr,
  input  wire logic [63:0]       pwdata,
  output logic      [63:0]       prdata,
  output logic                   pready
);

  logic [63:0]  cfg_q [RegCount];
  logic [127:0] rkey_q, rkey_d;
  state_e       state_q, state_d;
  phase_e       phase_q, phase_d;
  logic [3:0]   rnd_q, rnd_d;
  logic [127:0] st_q, st_d;
  logic [255:0] kw_q, kw_d;
  logic [7:0]   rc_q, rc_d;
  req_t         req_q;
  logic [127:0] ks_q, ks_d;
  logic         ov_q, ov_d;
  rsp_t         out_q, out_d;
  logic [127:0] rk_cur, rnd_out, stream_out;
  logic [3:0]   nr;
  logic         last;
  logic         wr_en;
  logic [2:0]   widx;

  assign pready = 1'b1;
  assign widx   = paddr[5:3];
  assign wr_en  = psel && penable && pwrite && (paddr[2:0] == 3'd0);
  assign prdata = (paddr[2:0] == 3'd0) ? cfg_q[widx] : 64'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RegCount; i++) cfg_q[i] <= '0;
    end else if (wr_en) begin
      cfg_q[widx] <= pwdata;
    end
  end

  // Round key for the current round: AES-256 alternates window halves.
  assign nr     = (phase_q == PhStream) ? 4'd10 : 4'd14;
  assign last   = (rnd_q == nr);
  assign rk_cur = (phase_q == PhStream) ? kw_q[127:0]
                : (rnd_q[0] ? kw_q[255:128] : kw_q[127:0]);
  assign rnd_out    = aes_round(st_q, last) ^ rk_cur;
  assign stream_out = {req_q.in_hi, req_q.in_lo} ^ ks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      phase_q <= PhStream;
      rnd_q   <= '0;
      ov_q    <= 1'b0;
      rkey_q  <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      rnd_q   <= rnd_d;
      ov_q    <= ov_d;
      rkey_q  <= rkey_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q  <= st_d;
    kw_q  <= kw_d;
    rc_q  <= rc_d;
    ks_q  <= ks_d;
    out_q <= out_d;
    if (req_if.valid && req_if.ready) req_q <= req_if.payload;
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    rnd_d   = rnd_q;
    st_d    = st_q;
    kw_d    = kw_q;
    rc_d    = rc_q;
    ks_d    = ks_q;
    rkey_d  = rkey_q;
    ov_d    = ov_q;
    out_d   = out_q;
    if (rsp_if.valid && rsp_if.ready) ov_d = 1'b0;
    case (state_q)
      StIdle: begin
        if (req_if.valid && !ov_q) begin
          phase_d = req_if.payload.first ? PhDerive : PhStream;
          state_d = StLoad;
        end
      end
      StLoad: begin
        rnd_d = 4'd1;
        rc_d  = 8'h01;
        case (phase_q)
          PhDerive: begin
            kw_d = {cfg_q[RegMk3], cfg_q[RegMk2], cfg_q[RegMk1], cfg_q[RegMk0]};
            st_d = {64'd0, req_q.sector} ^ kw_d[127:0];
          end
          PhStream: begin
            kw_d = {128'd0, kexp128(rkey_q, 8'h01)};
            st_d = {96'd0, req_q.block_index} ^ rkey_q;
            rc_d = 8'h02;
          end
          default: begin
            kw_d = {cfg_q[RegRk3], cfg_q[RegRk2], cfg_q[RegRk1], cfg_q[RegRk0]};
            st_d = rkey_q ^ (req_q.func ? {req_q.in_hi, req_q.in_lo} : stream_out)
                   ^ kw_d[127:0];
          end
        endcase
        state_d = StRound;
      end
      StRound: begin
        st_d  = rnd_out;
        rnd_d = rnd_q + 4'd1;
        if (phase_q == PhStream) begin
          kw_d = {128'd0, kexp128(kw_q[127:0], rc_q)};
          rc_d = next_rc(rc_q);
        end else if (rnd_q[0]) begin
          kw_d = kexp256(kw_q, rc_q);
          rc_d = next_rc(rc_q);
        end
        if (last) begin
          case (phase_q)
            PhDerive: begin
              rkey_d  = rnd_out;
              phase_d = PhStream;
              state_d = StLoad;
            end
            PhStream: begin
              ks_d    = rnd_out;
              phase_d = PhRatchet;
              state_d = StLoad;
            end
            default: begin
              rkey_d  = rnd_out;
              out_d   = '{out_hi: stream_out[127:64], out_lo: stream_out[63:0]};
              state_d = StDone;
            end
          endcase
        end
      end
      StDone: begin
        ov_d    = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign req_if.ready   = (state_q == StIdle) && !ov_q;
  assign rsp_if.valid   = ov_q;
  assign rsp_if.payload = out_q;

  `RCA_ASSERT(a_busy_not_ready, clk_i, rst_ni, (state_q != StIdle) |-> !req_if.ready)
  `RCA_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, req_if.valid && req_if.ready, state_q == StLoad)
  `RCA_ASSERT_NEXT(a_done_shows, clk_i, rst_ni, state_q == StDone, rsp_if.valid)
  `RCA_ASSERT(a_round_bound, clk_i, rst_ni, (state_q == StRound) |-> (rnd_q >= 4'd1 && rnd_q <= 4'd14))

endmodule
`default_nettype wire

@@ verif/ratchet_ctr_aes_sector_cipher_core_tb.sv @@
// ----------------------------------------------------------------------------
// ratchet_ctr_aes_sector_cipher_core_tb
// Drives blocks through the sector cipher and compares each output block with
// a local AES model of the sector-key derivation, the counter-mode keystream
// and the per-block key ratchet. Keys are rewritten between phases over APB.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ratchet_ctr_aes_sector_cipher_core_tb;
  import rca_pkg::*;

  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned RandItems = 1400;

  typedef struct {
    req_t        req;
    logic        known;
    logic [63:0] exp_hi;
    logic [63:0] exp_lo;
  } vec_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [AddrW-1:0] paddr;
  logic [63:0] pwdata, prdata;
  logic pready;

  rca_stream_if #(.T(req_t)) req_if ();
  rca_stream_if #(.T(rsp_t)) rsp_if ();

  ratchet_ctr_aes_sector_cipher_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_if  (req_if.sink),
    .rsp_if  (rsp_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [63:0] master_key [4];
  logic [63:0] ratchet_key [4];
  logic [127:0] chain_key;
  rsp_t cipher_q [$];
  int errors;
  int idle_cycles;
  int rsp_stall;
  bit sink_stall_en;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Byte i of a block sits in bits 8*i+7..8*i.
  function automatic logic [7:0] sb(input logic [7:0] a);
    logic [7:0] inv, p, q;
    logic [7:0] r;
    // Build the S-box from its definition: inverse in GF(2^8), then affine map.
    inv = 8'h00;
    if (a != 0) begin
      p = 8'h01;
      for (int k = 0; k < 254; k++) begin
        q = 8'h00;
        for (int j = 0; j < 8; j++) begin
          if (a[j]) q = q ^ (p << 0);
          p = {p[6:0], 1'b0} ^ (p[7] ? 8'h1b : 8'h00);
        end
        p = q;
      end
      inv = p;
    end
    for (int j = 0; j < 8; j++) begin
      r[j] = inv[j] ^ inv[(j+4)%8] ^ inv[(j+5)%8] ^ inv[(j+6)%8] ^ inv[(j+7)%8];
    end
    return r ^ 8'h63;
  endfunction

  logic [7:0] sbox_tbl [256];

  function automatic logic [7:0] mul2(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] aes_block(input logic [255:0] key, input int nk,
                                             input logic [127:0] blk);
    logic [7:0] w [240];
    logic [7:0] tmp [4];
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al, f, rc;
    logic [127:0] res;
    int nr, total;
    nr = nk + 6;
    total = 4 * (nr + 1);
    rc = 8'h01;
    for (int i = 0; i < 4 * nk; i++) w[i] = key[8*i +: 8];
    for (int i = nk; i < total; i++) begin
      for (int c = 0; c < 4; c++) tmp[c] = w[4*(i-1)+c];
      if (i % nk == 0) begin
        f = tmp[0];
        tmp[0] = sbox_tbl[tmp[1]] ^ rc;
        tmp[1] = sbox_tbl[tmp[2]];
        tmp[2] = sbox_tbl[tmp[3]];
        tmp[3] = sbox_tbl[f];
        rc = mul2(rc);
      end else if (nk > 6 && i % nk == 4) begin
        for (int c = 0; c < 4; c++) tmp[c] = sbox_tbl[tmp[c]];
      end
      for (int c = 0; c < 4; c++) w[4*i+c] = w[4*(i-nk)+c] ^ tmp[c];
    end
    for (int i = 0; i < 16; i++) s[i] = blk[8*i +: 8] ^ w[i];
    for (int r = 1; r <= nr; r++) begin
      for (int c = 0; c < 4; c++) begin
        for (int row = 0; row < 4; row++) begin
          t[c*4+row] = sbox_tbl[s[((c + row) % 4) * 4 + row]];
        end
      end
      if (r != nr) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          t[c*4]   = a0 ^ al ^ mul2(a0 ^ a1);
          t[c*4+1] = a1 ^ al ^ mul2(a1 ^ a2);
          t[c*4+2] = a2 ^ al ^ mul2(a2 ^ a3);
          t[c*4+3] = a3 ^ al ^ mul2(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ w[16*r+i];
    end
    for (int i = 0; i < 16; i++) res[8*i +: 8] = s[i];
    return res;
  endfunction

  function automatic rsp_t cipher_block(input req_t rq);
    logic [127:0] key, ks, inb, outb, ct;
    rsp_t rs;
    key = chain_key;
    if (rq.first) begin
      key = aes_block({master_key[3], master_key[2], master_key[1], master_key[0]}, 8,
                      {64'h0, rq.sector});
    end
    ks = aes_block({128'h0, key}, 4, {96'h0, rq.block_index});
    inb = {rq.in_hi, rq.in_lo};
    outb = inb ^ ks;
    ct = rq.func ? inb : outb;
    chain_key = aes_block({ratchet_key[3], ratchet_key[2], ratchet_key[1], ratchet_key[0]},
                          8, key ^ ct);
    rs.out_hi = outb[127:64];
    rs.out_lo = outb[63:0];
    return rs;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic reg_write(input reg_idx_e idx, input logic [63:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrW'(8 * int'(idx));
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx <= RegMk3) master_key[int'(idx)] = val;
    else ratchet_key[int'(idx) - 4] = val;
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic load_keys(input int mode);
    logic [63:0] v;
    for (int i = 0; i < 8; i++) begin
      case (mode)
        0: v = 64'h0;
        1: v = '1;
        default: v = rand64();
      endcase
      reg_write(reg_idx_e'(i), v);
    end
  endtask

  task automatic send_block(input req_t rq);
    rsp_t exp_rsp;
    int gap;
    exp_rsp = cipher_block(rq);
    cipher_q.push_back(exp_rsp);
    req_if.valid <= 1'b1;
    req_if.payload <= rq;
    do @(posedge clk_i); while (!req_if.ready);
    gap = gap_len();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic req_t rand_block(input logic [31:0] idx, input logic first);
    req_t rq;
    rq.func = 1'($urandom_range(0, 1));
    rq.first = first;
    rq.sector = ($urandom_range(0, 9) == 0) ? '1 : rand64();
    rq.block_index = ($urandom_range(0, 7) == 0) ? $urandom() : idx;
    rq.in_hi = rand64();
    rq.in_lo = rand64();
    return rq;
  endfunction

  // Response side: random stalls, in-order compare.
  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (cipher_q.size() == 0) begin
          $display("%0t: unexpected output %h_%h", $time, rsp_if.payload.out_hi,
                   rsp_if.payload.out_lo);
          errors++;
        end else begin
          exp_rsp = cipher_q.pop_front();
          if (rsp_if.payload.out_hi !== exp_rsp.out_hi) begin
            $display("%0t: out_hi expected %h actual %h", $time, exp_rsp.out_hi,
                     rsp_if.payload.out_hi);
            errors++;
          end
          if (rsp_if.payload.out_lo !== exp_rsp.out_lo) begin
            $display("%0t: out_lo expected %h actual %h", $time, exp_rsp.out_lo,
                     rsp_if.payload.out_lo);
            errors++;
          end
        end
      end
      if (rsp_stall != 0) begin
        rsp_if.ready <= 1'b0;
        rsp_stall <= rsp_stall - 1;
      end else begin
        rsp_if.ready <= 1'b1;
        if (sink_stall_en && ($urandom_range(0, 3) == 0)) rsp_stall <= gap_len() + 1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("ratchet_ctr_aes_sector_cipher_core_tb: done, errors");
      $finish;
    end
  end

  vec_t dir_tbl [$];

  initial begin
    vec_t v;
    req_t rq;
    logic [31:0] idx;
    errors = 0;
    idle_cycles = 0;
    rsp_stall = 0;
    sink_stall_en = 1'b0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_if.valid = 1'b0;
    req_if.payload = '0;
    rsp_if.ready = 1'b0;
    for (int i = 0; i < 256; i++) sbox_tbl[i] = sb(8'(i));
    for (int i = 0; i < 4; i++) begin
      master_key[i] = '0;
      ratchet_key[i] = '0;
    end
    chain_key = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero key, zero index, zero data: keystream is the AES-128 all-zero vector.
    v.req = '0;
    v.known = 1'b1;
    v.exp_hi = 64'h2e2b34ca59fa4c88;
    v.exp_lo = 64'h3b2c8aefd44be966;
    dir_tbl.push_back(v);
    v.known = 1'b0;
    v.req = '{func: 1'b1, first: 1'b0, sector: '0, block_index: '1, in_hi: '1, in_lo: '1};
    dir_tbl.push_back(v);
    v.req = '{func: 1'b0, first: 1'b1, sector: '0, block_index: '0, in_hi: '0, in_lo: '0};
    dir_tbl.push_back(v);
    v.req = '{func: 1'b1, first: 1'b1, sector: '1, block_index: '1, in_hi: '1, in_lo: '0};
    dir_tbl.push_back(v);
    v.req = '{func: 1'b0, first: 1'b0, sector: '1, block_index: 32'h1, in_hi: '0,
              in_lo: '1};
    dir_tbl.push_back(v);
    v.req = '{func: 1'b1, first: 1'b0, sector: '0, block_index: 32'h2,
              in_hi: 64'h8000_0000_0000_0001, in_lo: 64'h0123_4567_89ab_cdef};
    dir_tbl.push_back(v);

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].known) begin
        if (cipher_block(dir_tbl[i].req) !== {dir_tbl[i].exp_hi, dir_tbl[i].exp_lo}) begin
          $display("%0t: local model expected %h_%h", $time, dir_tbl[i].exp_hi,
                   dir_tbl[i].exp_lo);
          errors++;
        end
        chain_key = '0;
      end
      send_block(dir_tbl[i].req);
    end
    wait_drained();

    // Keys at all ones, then mid-sector key change.
    load_keys(1);
    for (int i = 0; i < 6; i++) send_block(rand_block(32'(i), i == 0));
    wait_drained();
    reg_write(RegMk0, rand64());
    reg_write(RegRk3, rand64());
    for (int i = 0; i < 6; i++) send_block(rand_block(32'(i + 6), i == 3));
    wait_drained();

    sink_stall_en = 1'b1;
    idx = 0;
    for (int n = 0; n < RandItems; n++) begin
      if (n % 350 == 0) begin
        wait_drained();
        load_keys((n == 700) ? 0 : 2);
      end
      if ($urandom_range(0, 9) == 0) idx = 0;
      rq = rand_block(idx, (idx == 0) || ($urandom_range(0, 19) == 0));
      send_block(rq);
      idx = idx + 1;
      if (n == 500) wait_drained();
    end
    wait_drained();

    if (errors == 0) begin
      $display("ratchet_ctr_aes_sector_cipher_core_tb: done, clean");
    end else begin
      $display("ratchet_ctr_aes_sector_cipher_core_tb: done, errors");
    end
    $finish;
  end

endmodule
